// ===== hdl/swec_pkg.sv =====
// Shared types and constants of the sensor window slew EMA conditioner.
`default_nettype none

package swec_pkg;

  // Window length and fraction bits of the running averages.
  localparam int WINDOW_LEN = 10;
  localparam int FRAC_BITS  = 8;

  // Field widths.
  localparam int TEMP_W    = 11;
  localparam int HUMID_W   = 10;
  localparam int CNT_W     = 8;
  localparam int TIME_W    = 32;
  localparam int STD_W     = 14;
  localparam int ALPHA_W   = 16;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int AVG_T_W = TEMP_W + FRAC_BITS;
  localparam int AVG_H_W = HUMID_W + FRAC_BITS;
  localparam int AVG_W   = (AVG_T_W > AVG_H_W) ? AVG_T_W : AVG_H_W + 1;

  // Window statistics widths.
  localparam int IDX_W     = $clog2(WINDOW_LEN);
  localparam int N_W       = $clog2(WINDOW_LEN + 1);
  localparam int SQ_W      = 2 * TEMP_W - 1;
  localparam int S1_W      = TEMP_W + IDX_W;
  localparam int S2_W      = SQ_W + IDX_W;
  localparam int VAR_W     = N_W + S2_W;
  localparam int VAR_SHIFT = 8;
  localparam int NUM_W     = VAR_W + VAR_SHIFT;
  localparam int DEN_W     = 2 * N_W;
  localparam int SQIN_W    = NUM_W + (NUM_W % 2);
  localparam int ROOT_W    = SQIN_W / 2;
  localparam int CYC_W     = $clog2(NUM_W + 1);
  localparam int STD_MAX   = (1 << STD_W) - 1;

  // Average update widths.
  localparam int SAMP_W = AVG_W + 2;
  localparam int DIFF_W = SAMP_W + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;
  localparam int ROUND  = 1 << (ALPHA_W - 1);

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0]   MAX_FAILS_RST = 8'd5;
  localparam logic [TIME_W-1:0]  REC_INT_RST   = 32'd600000;
  localparam logic [STD_W-1:0]   JIT_THR_RST   = 14'd80;
  localparam logic [TEMP_W-1:0]  SLEW_T_RST    = 11'd20;
  localparam logic [HUMID_W-1:0] SLEW_H_RST    = 10'd50;
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 16'd3277;

  typedef enum logic [STATUS_W-1:0] {
    STS_UPDATED      = 3'd0,
    STS_FAIL_COUNTED = 3'd1,
    STS_DISABLED     = 3'd2,
    STS_SKIPPED      = 3'd3,
    STS_RECOV_FAILED = 3'd4,
    STS_RESET        = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_FAILS = 3'd0,
    CFG_REC_INT   = 3'd1,
    CFG_JIT_THR   = 3'd2,
    CFG_SLEW_T    = 3'd3,
    CFG_SLEW_H    = 3'd4,
    CFG_ALPHA     = 3'd5
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_READ  = 1'b0,
    OP_RESET = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_VAR,
    ST_DIVSET,
    ST_DIV,
    ST_SQSET,
    ST_SQRT,
    ST_STD,
    ST_SLEW,
    ST_MUL,
    ST_ADD,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/sensor_window_slew_ema_conditioner_top.sv =====
// Top level of the sensor window slew EMA conditioner.
//
//  Channel | Direction | Handshake             | Beat
//  in      | input     | in_valid_i/in_stall_o | opcode, time, read flag, temp, humidity
//  out     | output    | out_valid_o/out_stall_i | status, health, averages, std dev
//  cfg     | input     | cfg_valid_i/cfg_ready_o | register index and data
//
// For a good reading the window sum walks one entry a cycle over the entries in use
// (up to 10), the divider retires one quotient bit a cycle and the square root one
// result bit a cycle. The first good reading, which has no average to slew against
// yet, skips the slew, multiply and add steps. Every other beat goes from idle
// straight to the finish state. Reset is asynchronous and clears all control
// state; no clearing pass is needed. A new beat is taken while the last result
// waits on a stalled output; it then finishes and holds until the output
// register frees.
`default_nettype none

module sensor_window_slew_ema_conditioner_top
  import swec_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Input channel.
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 opcode_i,
  input  wire logic [TIME_W-1:0]    now_ms_i,
  input  wire logic                 read_ok_i,
  input  wire logic [TEMP_W-1:0]    temp_tenths_i,
  input  wire logic [HUMID_W-1:0]   humid_tenths_i,
  // Output channel.
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic                      sensor_enabled_o,
  output logic [CNT_W-1:0]          fail_count_o,
  output logic [AVG_T_W-1:0]        avg_temp_o,
  output logic [AVG_H_W-1:0]        avg_humid_o,
  output logic [STD_W-1:0]          std_dev_o,
  output logic                      jitter_warning_o,
  // Configuration channel.
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  // Configuration registers.
  logic [CNT_W-1:0]   max_fails_q;
  logic [TIME_W-1:0]  rec_int_q;
  logic [STD_W-1:0]   jit_thr_q;
  logic [TEMP_W-1:0]  slew_t_q;
  logic [HUMID_W-1:0] slew_h_q;
  logic [ALPHA_W-1:0] alpha_q;

  // Health and window state.
  logic signed [TEMP_W-1:0] win_q [WINDOW_LEN];
  logic [IDX_W-1:0]         widx_q;
  logic                     full_q;
  logic                     en_q;
  logic [CNT_W-1:0]         fc_q;
  logic [TIME_W-1:0]        last_rec_q;
  logic signed [AVG_W-1:0]  avg_t_q;
  logic signed [AVG_W-1:0]  avg_h_q;
  logic                     have_q;
  logic [STD_W-1:0]         std_q;
  status_e                  status_q;

  // Work registers of one reading.
  logic signed [TEMP_W-1:0] t_q;
  logic [HUMID_W-1:0]       h_q;
  logic [N_W-1:0]           n_q;
  logic [N_W-1:0]           k_q;
  logic signed [S1_W-1:0]   s1_q;
  logic [S2_W-1:0]          s2_q;
  logic [VAR_W-1:0]         ns2_q;
  logic [2*S1_W-1:0]        s1sq_q;
  logic [DEN_W-1:0]         den_q;
  logic [NUM_W-1:0]         dvd_q;
  logic [DEN_W-1:0]         rem_q;
  logic [CYC_W-1:0]         cyc_q;
  logic [SQIN_W-1:0]        sx_q;
  logic [ROOT_W-1:0]        root_q;
  logic [ROOT_W:0]          srem_q;
  logic                     chan_q;
  logic signed [SAMP_W-1:0] samp_q;
  logic signed [PROD_W-1:0] prod_q;

  // Output register.
  logic                     out_valid_q;
  logic [STATUS_W-1:0]      out_status_q;
  logic                     out_en_q;
  logic [CNT_W-1:0]         out_fc_q;
  logic [AVG_T_W-1:0]       out_avg_t_q;
  logic [AVG_H_W-1:0]       out_avg_h_q;
  logic [STD_W-1:0]         out_std_q;
  logic                     out_jit_q;

  // Health decision on the incoming beat.
  logic [TIME_W-1:0] elapsed;
  logic              due;
  logic              recov;
  logic              attempt;
  logic              good;
  logic [CNT_W-1:0]  fc_inc;
  logic              wrap;
  logic              accept;
  logic              out_load;

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign elapsed  = now_ms_i - last_rec_q;
  assign due      = elapsed >= rec_int_q;
  assign recov    = due && !en_q;
  assign attempt  = en_q || recov;
  assign good     = (opcode_i == OP_READ) && attempt && read_ok_i;
  assign fc_inc   = (fc_q == {CNT_W{1'b1}}) ? fc_q : fc_q + CNT_W'(1);
  assign wrap     = widx_q == IDX_W'(WINDOW_LEN - 1);
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  // Window walk: one entry and its square per cycle.
  logic signed [TEMP_W-1:0]   elem;
  logic signed [2*TEMP_W-1:0] sq_c;
  assign elem = win_q[k_q[IDX_W-1:0]];
  assign sq_c = elem * elem;

  logic signed [2*S1_W-1:0] s1sq_c;
  logic [VAR_W-1:0]         var_c;
  assign s1sq_c = s1_q * s1_q;
  assign var_c  = ns2_q - s1sq_q[VAR_W-1:0];

  // Restoring divider step.
  logic [DEN_W:0] dv_trial;
  logic [DEN_W:0] dv_sub;
  logic           dv_ge;
  assign dv_trial = {rem_q, dvd_q[NUM_W-1]};
  assign dv_sub   = dv_trial - {1'b0, den_q};
  assign dv_ge    = dv_trial >= {1'b0, den_q};

  // Square root step, two radicand bits per cycle.
  logic [ROOT_W+2:0] sq_cur;
  logic [ROOT_W+2:0] sq_trial;
  logic [ROOT_W+2:0] sq_sub;
  logic              sq_ge;
  assign sq_cur   = {srem_q, sx_q[SQIN_W-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_sub   = sq_cur - sq_trial;
  assign sq_ge    = sq_cur >= sq_trial;

  // Slew limiting and average update on the selected channel.
  logic signed [AVG_W-1:0]  avg_sel;
  logic signed [SAMP_W-1:0] sl_smp;
  logic signed [SAMP_W-1:0] sl_avg;
  logic signed [SAMP_W-1:0] sl_lim;
  logic signed [SAMP_W-1:0] sl_dif;
  logic signed [SAMP_W-1:0] sl_res;
  logic [TEMP_W-1:0]        lim_raw;
  logic signed [DIFF_W-1:0] mu_dif;
  logic signed [PROD_W-1:0] ad_rnd;
  logic signed [PROD_W-1:0] ad_step;
  logic signed [AVG_W-1:0]  ad_new;

  assign avg_sel = chan_q ? avg_h_q : avg_t_q;
  assign lim_raw = chan_q ? TEMP_W'(slew_h_q) : slew_t_q;
  assign sl_smp  = chan_q ? $signed(SAMP_W'({h_q, {FRAC_BITS{1'b0}}}))
                          : SAMP_W'($signed({t_q, {FRAC_BITS{1'b0}}}));
  assign sl_avg  = SAMP_W'(avg_sel);
  assign sl_lim  = $signed(SAMP_W'({lim_raw, {FRAC_BITS{1'b0}}}));
  assign sl_dif  = sl_smp - sl_avg;

  always_comb begin
    if (sl_dif > sl_lim) begin
      sl_res = sl_avg + sl_lim;
    end else if (sl_dif < -sl_lim) begin
      sl_res = sl_avg - sl_lim;
    end else begin
      sl_res = sl_smp;
    end
  end

  assign mu_dif  = DIFF_W'(samp_q) - DIFF_W'(avg_sel);
  assign ad_rnd  = prod_q + PROD_W'(ROUND);
  assign ad_step = ad_rnd >>> ALPHA_W;
  assign ad_new  = avg_sel + ad_step[AVG_W-1:0];

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = good ? ST_SUM : ST_FIN;
        end
      end
      ST_SUM: begin
        if (k_q + N_W'(1) == n_q) begin
          state_d = ST_VAR;
        end
      end
      ST_VAR:    state_d = ST_DIVSET;
      ST_DIVSET: state_d = ST_DIV;
      ST_DIV: begin
        if (cyc_q == CYC_W'(NUM_W - 1)) begin
          state_d = ST_SQSET;
        end
      end
      ST_SQSET:  state_d = ST_SQRT;
      ST_SQRT: begin
        if (cyc_q == CYC_W'(ROOT_W - 1)) begin
          state_d = ST_STD;
        end
      end
      ST_STD:    state_d = have_q ? ST_SLEW : ST_FIN;
      ST_SLEW:   state_d = ST_MUL;
      ST_MUL:    state_d = ST_ADD;
      ST_ADD:    state_d = chan_q ? ST_FIN : ST_SLEW;
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fails_q <= MAX_FAILS_RST;
      rec_int_q   <= REC_INT_RST;
      jit_thr_q   <= JIT_THR_RST;
      slew_t_q    <= SLEW_T_RST;
      slew_h_q    <= SLEW_H_RST;
      alpha_q     <= ALPHA_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_FAILS: max_fails_q <= cfg_data_i[CNT_W-1:0];
        CFG_REC_INT:   rec_int_q   <= cfg_data_i[TIME_W-1:0];
        CFG_JIT_THR:   jit_thr_q   <= cfg_data_i[STD_W-1:0];
        CFG_SLEW_T:    slew_t_q    <= cfg_data_i[TEMP_W-1:0];
        CFG_SLEW_H:    slew_h_q    <= cfg_data_i[HUMID_W-1:0];
        CFG_ALPHA:     alpha_q     <= cfg_data_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Window storage, written once per good reading.
  always_ff @(posedge clk_i) begin
    if (accept && good) begin
      win_q[widx_q] <= temp_tenths_i;
    end
  end

  // Health, window control and averages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q     <= '0;
      full_q     <= 1'b0;
      en_q       <= 1'b1;
      fc_q       <= '0;
      last_rec_q <= '0;
      avg_t_q    <= '0;
      avg_h_q    <= '0;
      have_q     <= 1'b0;
      std_q      <= '0;
      status_q   <= STS_UPDATED;
    end else begin
      if (accept) begin
        if (opcode_i == OP_RESET) begin
          fc_q     <= '0;
          full_q   <= 1'b0;
          widx_q   <= '0;
          en_q     <= 1'b1;
          status_q <= STS_RESET;
        end else begin
          if (due) begin
            last_rec_q <= now_ms_i;
          end
          if (!attempt) begin
            status_q <= STS_SKIPPED;
          end else if (read_ok_i) begin
            fc_q     <= '0;
            en_q     <= 1'b1;
            status_q <= STS_UPDATED;
            widx_q   <= wrap ? '0 : widx_q + IDX_W'(1);
            if (wrap) begin
              full_q <= 1'b1;
            end
          end else if (en_q) begin
            fc_q <= fc_inc;
            if (fc_inc >= max_fails_q) begin
              en_q     <= 1'b0;
              status_q <= STS_DISABLED;
            end else begin
              status_q <= STS_FAIL_COUNTED;
            end
          end else begin
            status_q <= STS_RECOV_FAILED;
          end
        end
      end

      // Saturated standard deviation, and the first average taken as is.
      if (state_q == ST_STD) begin
        std_q <= (root_q > ROOT_W'(STD_MAX)) ? STD_W'(STD_MAX) : root_q[STD_W-1:0];
        if (!have_q) begin
          avg_t_q <= AVG_W'($signed({t_q, {FRAC_BITS{1'b0}}}));
          avg_h_q <= $signed(AVG_W'({h_q, {FRAC_BITS{1'b0}}}));
          have_q  <= 1'b1;
        end
      end

      if (state_q == ST_ADD) begin
        if (chan_q) begin
          avg_h_q <= ad_new;
        end else begin
          avg_t_q <= ad_new;
        end
      end
    end
  end

  // Statistics, divider, square root and average work registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        t_q  <= temp_tenths_i;
        h_q  <= humid_tenths_i;
        n_q  <= (wrap || full_q) ? N_W'(WINDOW_LEN) : N_W'(widx_q) + N_W'(1);
        k_q  <= '0;
        s1_q <= '0;
        s2_q <= '0;
      end
      ST_SUM: begin
        s1_q <= s1_q + S1_W'(elem);
        s2_q <= s2_q + S2_W'(sq_c[SQ_W-1:0]);
        k_q  <= k_q + N_W'(1);
      end
      ST_VAR: begin
        ns2_q  <= VAR_W'(n_q) * VAR_W'(s2_q);
        s1sq_q <= s1sq_c;
        den_q  <= DEN_W'(n_q) * DEN_W'(n_q);
      end
      ST_DIVSET: begin
        dvd_q <= {var_c, {VAR_SHIFT{1'b0}}};
        rem_q <= '0;
        cyc_q <= '0;
      end
      ST_DIV: begin
        rem_q <= dv_ge ? dv_sub[DEN_W-1:0] : dv_trial[DEN_W-1:0];
        dvd_q <= {dvd_q[NUM_W-2:0], dv_ge};
        cyc_q <= cyc_q + CYC_W'(1);
      end
      ST_SQSET: begin
        sx_q   <= SQIN_W'(dvd_q);
        root_q <= '0;
        srem_q <= '0;
        cyc_q  <= '0;
      end
      ST_SQRT: begin
        srem_q <= sq_ge ? sq_sub[ROOT_W:0] : sq_cur[ROOT_W:0];
        root_q <= {root_q[ROOT_W-2:0], sq_ge};
        sx_q   <= sx_q << 2;
        cyc_q  <= cyc_q + CYC_W'(1);
      end
      ST_STD: begin
        chan_q <= 1'b0;
      end
      ST_SLEW: begin
        samp_q <= sl_res;
      end
      ST_MUL: begin
        prod_q <= PROD_W'(mu_dif) * PROD_W'($signed({1'b0, alpha_q}));
      end
      ST_ADD: begin
        chan_q <= 1'b1;
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_en_q     <= en_q;
      out_fc_q     <= fc_q;
      out_avg_t_q  <= avg_t_q[AVG_T_W-1:0];
      out_avg_h_q  <= avg_h_q[AVG_H_W-1:0];
      out_std_q    <= std_q;
      out_jit_q    <= full_q && (std_q > jit_thr_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign sensor_enabled_o = out_en_q;
  assign fail_count_o     = out_fc_q;
  assign avg_temp_o       = out_avg_t_q;
  assign avg_humid_o      = out_avg_h_q;
  assign std_dev_o        = out_std_q;
  assign jitter_warning_o = out_jit_q;

endmodule

`default_nettype wire

// ===== hdl/swec_checker.sv =====
// Port-level checks of the conditioner and their bind to the top level.
`default_nettype none

module swec_checker
  import swec_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [STATUS_W-1:0]  status_o,
  input wire logic                 sensor_enabled_o,
  input wire logic [CNT_W-1:0]     fail_count_o,
  input wire logic [STD_W-1:0]     std_dev_o,
  input wire logic                 jitter_warning_o
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A reset command leaves a healthy sensor with no failures.
  a_reset_health: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STS_RESET) |-> sensor_enabled_o && (fail_count_o == '0))
    else $error("reset command did not restore health");

  // A good reading clears the failure count and enables the sensor.
  a_update_health: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STS_UPDATED) |-> sensor_enabled_o && (fail_count_o == '0))
    else $error("good reading left sensor unhealthy");

  // Skipped, disabling and failed recovery beats report a disabled sensor.
  a_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == STS_SKIPPED) || (status_o == STS_DISABLED) ||
                    (status_o == STS_RECOV_FAILED)) |-> !sensor_enabled_o)
    else $error("disabled status with sensor enabled");

  // Jitter needs a nonzero deviation above the threshold.
  a_jitter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && jitter_warning_o |-> (std_dev_o != '0))
    else $error("jitter warning with zero deviation");

endmodule

bind sensor_window_slew_ema_conditioner_top swec_checker u_swec_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .sensor_enabled_o (sensor_enabled_o),
  .fail_count_o     (fail_count_o),
  .std_dev_o        (std_dev_o),
  .jitter_warning_o (jitter_warning_o)
);

`default_nettype wire
